// File: design/klfsa_pkg.sv
// ----------------------------------------------------------------------------
// klfsa_pkg
// Shared widths, codes and types of the keyed lowest-free slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package klfsa_pkg;

    // Payload widths fixed by the channel definitions.
    localparam int OPCODE_W = 2;
    localparam int TAG_W    = 32;
    localparam int INDEX_W  = 5;
    localparam int STATUS_W = 2;

    // Defaults for the top-level parameters.
    localparam int SLOT_COUNT_DEF = 32;
    localparam int TAG_BITS_DEF   = 32;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Request opcodes.
    localparam logic [OPCODE_W-1:0] OP_GET    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_LOCK   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_UNLOCK = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE_FREE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_UNIT  = 2'd3;

    // Classified command kind.
    typedef enum logic [1:0] {
        KIND_GET,
        KIND_LOCK,
        KIND_UNLOCK
    } kind_t;

    // One queued command.
    typedef struct packed {
        kind_t             kind;
        logic [TAG_W-1:0]  tag;
    } cmd_t;

    // Head of the command queue as seen by the back end.
    typedef struct packed {
        logic  valid;
        cmd_t  cmd;
    } queue_head_t;

endpackage

`default_nettype wire

// File: design/klfsa_req_if.sv
// ----------------------------------------------------------------------------
// klfsa_req_if
// Request channel: opcode and owner tag with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface klfsa_req_if;
    import klfsa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OPCODE_W-1:0]  opcode;
    logic [TAG_W-1:0]     owner_tag;

    modport source (output valid, output opcode, output owner_tag, input ready);
    modport sink   (input valid, input opcode, input owner_tag, output ready);
endinterface

`default_nettype wire

// File: design/klfsa_rsp_if.sv
// ----------------------------------------------------------------------------
// klfsa_rsp_if
// Result channel: slot index and status with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface klfsa_rsp_if;
    import klfsa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [INDEX_W-1:0]   slot_index;
    logic [STATUS_W-1:0]  status;

    modport source (output valid, output slot_index, output status, input ready);
    modport sink   (input valid, input slot_index, input status, output ready);
endinterface

`default_nettype wire

// File: design/klfsa_front.sv
// ----------------------------------------------------------------------------
// klfsa_front
// Accepts request words, classifies the opcode and queues the commands.
// ----------------------------------------------------------------------------
`default_nettype none

module klfsa_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    klfsa_req_if.sink                   req,
    output klfsa_pkg::queue_head_t      head,
    input  wire logic                   pop
);
    import klfsa_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push;
    cmd_t              in_cmd;

    // Opcode classification; the unused code is treated as a get.
    always_comb
    begin
        in_cmd.tag = req.owner_tag;
        case (req.opcode)
            OP_LOCK:   in_cmd.kind = KIND_LOCK;
            OP_UNLOCK: in_cmd.kind = KIND_UNLOCK;
            default:   in_cmd.kind = KIND_GET;
        endcase
    end

    // The queue takes a word whenever it has room.
    assign req.ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push      = req.valid && req.ready;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.cmd   = slot_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// File: design/klfsa_back.sv
// ----------------------------------------------------------------------------
// klfsa_back
// Slot table with parallel tag compare, lowest-free priority encoder and
// the registered result word.
// ----------------------------------------------------------------------------
`default_nettype none

module klfsa_back #(
    parameter int SLOT_COUNT = klfsa_pkg::SLOT_COUNT_DEF,
    parameter int TAG_BITS   = klfsa_pkg::TAG_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire klfsa_pkg::queue_head_t head,
    output logic                        pop,
    klfsa_rsp_if.source                 rsp
);
    import klfsa_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int KEY_W = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

    logic [SLOT_COUNT-1:0]  busy_reg, busy_next;
    logic [KEY_W-1:0]       owner_reg [SLOT_COUNT];
    logic                   out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]     slot_index_reg, slot_index_next;
    logic [STATUS_W-1:0]    status_reg, status_next;

    logic [KEY_W-1:0]       key;
    logic [SLOT_COUNT-1:0]  hit_vec, hit_low, free_vec, free_low;
    logic [IDX_W-1:0]       hit_idx, free_idx, res_idx;
    logic                   any_hit, any_free, owner_we;

    assign key = head.cmd.tag[KEY_W-1:0];

    // Parallel compare of the key against every busy slot.
    always_comb
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            hit_vec[i] = busy_reg[i] && (owner_reg[i] == key);
        end
    end

    // Isolate the lowest set bit of each vector and encode it.
    assign free_vec = ~busy_reg;
    assign hit_low  = hit_vec & (~hit_vec + SLOT_COUNT'(1));
    assign free_low = free_vec & (~free_vec + SLOT_COUNT'(1));
    assign any_hit  = |hit_vec;
    assign any_free = |free_vec;

    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (hit_low[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
            if (free_low[i])
            begin
                free_idx = free_idx | IDX_W'(i);
            end
        end
    end

    // A command is taken when the result register is free or being emptied.
    assign pop = head.valid && (!out_valid_reg || rsp.ready);

    // Command execution.
    always_comb
    begin
        busy_next   = busy_reg;
        owner_we    = 1'b0;
        res_idx     = '0;
        status_next = ST_OK;
        case (head.cmd.kind)
            KIND_LOCK:
            begin
                if (any_hit)
                begin
                    res_idx = hit_idx;
                end
                else if (any_free)
                begin
                    res_idx             = free_idx;
                    owner_we            = pop;
                    busy_next[free_idx] = 1'b1;
                end
                else
                begin
                    status_next = ST_NONE_FREE;
                end
            end
            KIND_UNLOCK:
            begin
                if (any_hit)
                begin
                    res_idx            = hit_idx;
                    busy_next[hit_idx] = 1'b0;
                end
                else
                begin
                    status_next = ST_BAD_UNIT;
                end
            end
            default:
            begin
                if (any_hit)
                begin
                    res_idx = hit_idx;
                end
                else
                begin
                    status_next = ST_UNKNOWN;
                end
            end
        endcase
        slot_index_next = INDEX_W'(res_idx);
    end

    // Result register valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= busy_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Owner tags and result payload carry no reset.
    always_ff @(posedge clk)
    begin
        if (owner_we)
        begin
            owner_reg[free_idx] <= key;
        end
        if (pop)
        begin
            slot_index_reg <= slot_index_next;
            status_reg     <= status_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.slot_index = slot_index_reg;
    assign rsp.status     = status_reg;

    // A key never holds more than one slot.
    a_single_owner: assert property (@(posedge clk) disable iff (!rst_n)
        head.valid |-> $onehot0(hit_vec))
        else $error("key matches more than one busy slot");

    // Every error result carries slot index zero.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg != ST_OK) |-> (slot_index_reg == '0))
        else $error("error result with nonzero slot index");

    // A granting lock marks exactly one more slot busy.
    a_lock_grant: assert property (@(posedge clk) disable iff (!rst_n)
        pop && (head.cmd.kind == KIND_LOCK) && !any_hit && any_free
        |=> ($countones(busy_reg) == $past($countones(busy_reg)) + 1))
        else $error("lock grant did not take exactly one slot");

    // A successful unlock frees exactly one slot.
    a_unlock_free: assert property (@(posedge clk) disable iff (!rst_n)
        pop && (head.cmd.kind == KIND_UNLOCK) && any_hit
        |=> ($countones(busy_reg) + 1 == $past($countones(busy_reg))))
        else $error("unlock did not free exactly one slot");

endmodule

`default_nettype wire

// File: design/keyed_lowest_free_slot_allocator.sv
// ----------------------------------------------------------------------------
// keyed_lowest_free_slot_allocator
// Hands out slots to owner tags: lock, get and unlock with the lowest free
// slot granted first.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Words carried
//   req       in         opcode, owner_tag
//   rsp       out        slot_index, status (one result word per request)
//
// One request word is accepted per cycle and one result word is produced per
// cycle while the result channel is not stalled; the combinational tag compare
// and priority encoder in the back end set that rate. A request is first
// written into the command queue, and its result is then held in the registered
// result word of the back end. Reset clears the busy map at once, so every slot
// is free; no clearing pass. A stalled result register holds the back end, and
// the two-entry command queue keeps accepting words until it is full.
`default_nettype none

module keyed_lowest_free_slot_allocator #(
    parameter int SLOT_COUNT = klfsa_pkg::SLOT_COUNT_DEF,
    parameter int TAG_BITS   = klfsa_pkg::TAG_BITS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    klfsa_req_if.sink   req,
    klfsa_rsp_if.source rsp
);
    import klfsa_pkg::*;

    queue_head_t  head;
    logic         pop;

    // Front end: accept and classify.
    klfsa_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .head  (head),
        .pop   (pop)
    );

    // Back end: slot table and result register.
    klfsa_back #(
        .SLOT_COUNT (SLOT_COUNT),
        .TAG_BITS   (TAG_BITS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

// File: tb/sv/klfsa_slot_checker.sv
// ----------------------------------------------------------------------------
// klfsa_slot_checker
// Watches both channels of the slot allocator. It predicts the result word for
// each accepted request and compares it with the next accepted result word.
// ----------------------------------------------------------------------------
module klfsa_slot_checker #(
    parameter int SLOT_COUNT = klfsa_pkg::SLOT_COUNT_DEF,
    parameter int TAG_BITS   = klfsa_pkg::TAG_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    klfsa_req_if req,
    klfsa_rsp_if rsp,
    output int   mismatch_count,
    output int   outstanding
);
    import klfsa_pkg::*;

    typedef struct packed {
        logic [INDEX_W-1:0]  slot;
        logic [STATUS_W-1:0] status;
    } slot_result_t;

    localparam logic [TAG_W-1:0] TAG_MASK = {TAG_W{1'b1}} >> (TAG_W - TAG_BITS);

    // Shadow copy of the allocation table.
    logic             slot_busy  [SLOT_COUNT];
    logic [TAG_W-1:0] slot_owner [SLOT_COUNT];

    // Result words predicted but not yet seen, oldest first.
    slot_result_t expected_results [$];

    // Applies one request to the shadow table and returns its result word.
    function automatic slot_result_t apply_request(logic [OPCODE_W-1:0] op,
                                                   logic [TAG_W-1:0] tag);
        int           hit;
        int           free_slot;
        logic [TAG_W-1:0] key;
        slot_result_t res;
        key = tag & TAG_MASK;
        hit = -1;
        free_slot = -1;
        res.slot = '0;
        res.status = ST_OK;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (hit < 0 && slot_busy[i] && slot_owner[i] == key)
                hit = i;
            if (free_slot < 0 && !slot_busy[i])
                free_slot = i;
        end
        if (op == OP_LOCK)
        begin
            // A holder keeps its slot; a newcomer takes the lowest free one.
            if (hit >= 0)
                res.slot = hit[INDEX_W-1:0];
            else if (free_slot < 0)
                res.status = ST_NONE_FREE;
            else
            begin
                slot_busy[free_slot] = 1'b1;
                slot_owner[free_slot] = key;
                res.slot = free_slot[INDEX_W-1:0];
            end
        end
        else if (op == OP_UNLOCK)
        begin
            if (hit >= 0)
            begin
                slot_busy[hit] = 1'b0;
                res.slot = hit[INDEX_W-1:0];
            end
            else
                res.status = ST_BAD_UNIT;
        end
        else
        begin
            // Get, and the spare opcode which decodes as get.
            if (hit >= 0)
                res.slot = hit[INDEX_W-1:0];
            else
                res.status = ST_UNKNOWN;
        end
        return res;
    endfunction

    // Predict on each accepted request word, check each accepted result word.
    always @(posedge clk or negedge rst_n)
    begin
        slot_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_busy[i] = 1'b0;
                slot_owner[i] = '0;
            end
            expected_results.delete();
            mismatch_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (req.valid && req.ready)
                expected_results.insert(expected_results.size(),
                                        apply_request(req.opcode, req.owner_tag));
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result word with nothing expected: slot %0d status %0d",
                             $time, rsp.slot_index, rsp.status);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.slot_index !== want.slot)
                    begin
                        mismatch_count++;
                        $display("%0t: slot_index expected %0d actual %0d",
                                 $time, want.slot, rsp.slot_index);
                    end
                    if (rsp.status !== want.status)
                    begin
                        mismatch_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, rsp.status);
                    end
                end
            end
            outstanding = expected_results.size();
        end
    end

endmodule

// File: tb/sv/keyed_lowest_free_slot_allocator_tb.sv
// ----------------------------------------------------------------------------
// keyed_lowest_free_slot_allocator_tb
// Drives lock, get and unlock requests into the slot allocator, first a short
// directed sequence and then random traffic over a small pool of owner tags so
// that the table fills and drains, with random gaps and result stalls.
// ----------------------------------------------------------------------------
module keyed_lowest_free_slot_allocator_tb;
    import klfsa_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;
    localparam int RANDOM_WORDS = 1700;
    localparam int POOL_SIZE    = 40;
    localparam int CYCLE_LIMIT  = 100000;

    logic clk;
    logic rst_n;
    bit   idle_on;
    int   mismatch_count;
    int   outstanding;
    int   cycle_count;
    logic [TAG_W-1:0] tag_pool [POOL_SIZE];

    klfsa_req_if req_ch ();
    klfsa_rsp_if rsp_ch ();

    keyed_lowest_free_slot_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    klfsa_slot_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Cycle counter that ends a hung run.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Result side: stall at random while idling is on.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready = !(idle_on && $urandom_range(99) < 17);
        end
    end

    // Offers one request word from a falling edge and returns at the falling
    // edge after it was taken.
    task automatic send_request(logic [OPCODE_W-1:0] op, logic [TAG_W-1:0] tag);
        while (idle_on && $urandom_range(99) < 17)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.opcode = op;
        req_ch.owner_tag = tag;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    initial
    begin
        int               pick;
        bit               fill_phase;
        logic [OPCODE_W-1:0] op;
        logic [TAG_W-1:0] tag;

        idle_on = 1'b1;
        req_ch.valid = 1'b0;
        req_ch.opcode = OP_GET;
        req_ch.owner_tag = '0;
        rst_n = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: unknown keys, repeat lock, lowest-free reuse, spare opcode.
        send_request(OP_GET, 32'h0000_0000);
        send_request(OP_UNLOCK, 32'hFFFF_FFFF);
        send_request(OP_LOCK, 32'h0000_0000);
        send_request(OP_LOCK, 32'h0000_0000);
        send_request(OP_LOCK, 32'hFFFF_FFFF);
        send_request(OP_LOCK, 32'hAAAA_AAAA);
        send_request(OP_LOCK, 32'h5555_5555);
        send_request(OP_GET, 32'hFFFF_FFFF);
        send_request(OP_UNLOCK, 32'h0000_0000);
        send_request(OP_GET, 32'h0000_0000);
        send_request(OP_LOCK, 32'h1234_5678);
        send_request(OP_SPARE, 32'h5555_5555);
        send_request(OP_SPARE, 32'h0000_0000);
        send_request(OP_UNLOCK, 32'hAAAA_AAAA);
        send_request(OP_UNLOCK, 32'hAAAA_AAAA);
        send_request(OP_LOCK, 32'h8000_0000);
        send_request(OP_LOCK, 32'h0000_0001);
        send_request(OP_UNLOCK, 32'hFFFF_FFFF);
        send_request(OP_UNLOCK, 32'h5555_5555);
        send_request(OP_UNLOCK, 32'h1234_5678);
        send_request(OP_UNLOCK, 32'h8000_0000);
        send_request(OP_UNLOCK, 32'h0000_0001);

        // Small pool of owners so the table fills up and drains again.
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            tag_pool[i] = $urandom;

        // Random traffic alternating between lock-heavy and unlock-heavy phases.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            idle_on = !(n >= 700 && n < 1000);
            fill_phase = ((n / 200) % 2) == 0;
            pick = $urandom_range(99);
            if (pick < (fill_phase ? 55 : 15))
                op = OP_LOCK;
            else if (pick < 65)
                op = OP_UNLOCK;
            else if (pick < 95)
                op = OP_GET;
            else
                op = OP_SPARE;
            if ($urandom_range(99) < 88)
                tag = tag_pool[$urandom_range(POOL_SIZE - 1)];
            else
                tag = $urandom;
            send_request(op, tag);
        end
        req_ch.valid = 1'b0;

        // Drain: every expected word must arrive, then allow for stragglers.
        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
